>>> src/afp_pkg.sv
// shared constants, result type, crc-8 step and decimal step for the ascii frame parser
// no dependencies
`timescale 1ns / 1ps

package afp_pkg;

  // frame geometry
  localparam int FRAME_BYTES = 32;
  localparam int POS_W       = $clog2(FRAME_BYTES);

  // characters and checksum constants
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CRC_INIT   = 8'hFF;
  localparam logic [7:0] CRC_POLY   = 8'h07;

  // field slots in frame order
  localparam logic [2:0] FLD_NODE    = 3'd0;
  localparam logic [2:0] FLD_REV     = 3'd1;
  localparam logic [2:0] FLD_VARIANT = 3'd2;
  localparam logic [2:0] FLD_CONFIG  = 3'd3;
  localparam logic [2:0] FLD_COMMAND = 3'd4;
  localparam logic [2:0] FLD_FIRST   = 3'd5;
  localparam logic [2:0] FLD_SECOND  = 3'd6;
  localparam logic [2:0] FLD_DONE    = 3'd7;

  localparam logic [5:0] SEG_LEN_MAX = 6'd63;

  typedef struct packed {
    logic        frame_valid;
    logic [7:0]  node_number;
    logic [7:0]  revision;
    logic [23:0] variant_code;
    logic [7:0]  config_number;
    logic [47:0] command_text;
    logic [15:0] first_value;
    logic [15:0] second_value;
    logic [7:0]  received_check;
  } afp_result_t;

  // one byte of crc-8, msb first, no final xor
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] x;
    x = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      x = x[7] ? ((x << 1) ^ CRC_POLY) : (x << 1);
    end
    return x;
  endfunction

  // decimal accumulate with byte minus '0' wrapping to 16 bits
  function automatic logic [15:0] dec_step(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] d;
    d = {8'h00, b} - {8'h00, CHAR_ZERO};
    return (acc << 3) + (acc << 1) + d;
  endfunction

endpackage

>>> src/afp_frame_core.sv
// per-byte frame state: crc, field segmentation, checksum digits, decoded fields
// depends on afp_pkg
`timescale 1ns / 1ps

module afp_frame_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic [7:0]           rx_byte,
  output logic                 last,
  output afp_pkg::afp_result_t res
);
  import afp_pkg::*;

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);

  logic [POS_W-1:0] pos;
  logic             text_ended, text_ended_next;
  logic             comma_seen, comma_seen_next;
  logic [7:0]       running_check, running_check_next;
  logic [7:0]       check_before_comma, check_before_comma_next;
  logic [15:0]      check_digits, check_digits_next;
  logic             check_bad_char, check_bad_char_next;
  logic [2:0]       field_number, field_number_next;
  logic [5:0]       seg_len, seg_len_next;
  logic [15:0]      seg_value, seg_value_next;
  logic [47:0]      seg_chars, seg_chars_next;
  logic [7:0]       first_byte, first_byte_next;
  logic [7:0]       node, node_next;
  logic [7:0]       rev, rev_next;
  logic [23:0]      variant, variant_next;
  logic [7:0]       cfg, cfg_next;
  logic [47:0]      cmd, cmd_next;
  logic [15:0]      val1, val1_next;
  logic [15:0]      val2, val2_next;

  assign last = (pos == LAST_POS);

  always_comb begin
    text_ended_next         = text_ended;
    comma_seen_next         = comma_seen;
    running_check_next      = running_check;
    check_before_comma_next = check_before_comma;
    check_digits_next       = check_digits;
    check_bad_char_next     = check_bad_char;
    field_number_next       = field_number;
    seg_len_next            = seg_len;
    seg_value_next          = seg_value;
    seg_chars_next          = seg_chars;
    first_byte_next         = (pos == '0) ? rx_byte : first_byte;
    node_next               = node;
    rev_next                = rev;
    variant_next            = variant;
    cfg_next                = cfg;
    cmd_next                = cmd;
    val1_next               = val1;
    val2_next               = val2;

    if (!text_ended) begin
      if (rx_byte == CHAR_NUL) begin
        text_ended_next = 1'b1;
      end else if (rx_byte == CHAR_COMMA) begin
        check_before_comma_next = running_check;
        comma_seen_next         = 1'b1;
        check_digits_next       = '0;
        check_bad_char_next     = 1'b0;
        // close the segment into its field slot
        case (field_number)
          FLD_NODE: begin
            if (seg_len inside {[6'd1:6'd3]}) node_next = seg_value[7:0];
          end
          FLD_REV: begin
            if (seg_len inside {[6'd1:6'd2]}) rev_next = seg_value[7:0];
          end
          FLD_VARIANT: begin
            if (seg_len <= 6'd3) variant_next = seg_chars[23:0];
          end
          FLD_CONFIG: begin
            if (seg_len inside {[6'd1:6'd2]}) cfg_next = seg_value[7:0];
          end
          FLD_COMMAND: begin
            if (seg_len <= 6'd6) cmd_next = seg_chars;
          end
          FLD_FIRST:  val1_next = seg_value;
          FLD_SECOND: val2_next = seg_value;
          default: ;
        endcase
        if (field_number != FLD_DONE) field_number_next = field_number + 3'd1;
        seg_len_next   = '0;
        seg_value_next = '0;
        seg_chars_next = '0;
      end else begin
        for (int i = 0; i < 6; i++) begin
          if (seg_len == 6'(i)) seg_chars_next[8*i +: 8] = rx_byte;
        end
        seg_value_next = dec_step(seg_value, rx_byte);
        if (seg_len != SEG_LEN_MAX) seg_len_next = seg_len + 6'd1;
        if (pos != '0) begin
          if (rx_byte < CHAR_ZERO || rx_byte > CHAR_NINE) check_bad_char_next = 1'b1;
          check_digits_next = dec_step(check_digits, rx_byte);
        end
      end
      if (rx_byte != CHAR_NUL) running_check_next = crc8_step(running_check, rx_byte);
    end
  end

  // result as it stands once this byte is folded in
  always_comb begin
    res = '0;
    if (first_byte_next != CHAR_NUL && !check_bad_char_next &&
        check_digits_next == {8'h00, check_before_comma_next}) begin
      res.frame_valid    = 1'b1;
      res.received_check = check_digits_next[7:0];
      if (comma_seen_next) begin
        res.node_number   = node_next;
        res.revision      = rev_next;
        res.variant_code  = variant_next;
        res.config_number = cfg_next;
        res.command_text  = cmd_next;
        res.first_value   = val1_next;
        res.second_value  = val2_next;
      end else begin
        res.node_number = first_byte_next - CHAR_ZERO;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (en && last)) begin
      pos                <= '0;
      text_ended         <= 1'b0;
      comma_seen         <= 1'b0;
      running_check      <= CRC_INIT;
      check_before_comma <= CRC_INIT;
      check_digits       <= '0;
      check_bad_char     <= 1'b0;
      field_number       <= FLD_NODE;
      seg_len            <= '0;
      seg_value          <= '0;
      seg_chars          <= '0;
      first_byte         <= '0;
      node               <= '0;
      rev                <= '0;
      variant            <= '0;
      cfg                <= '0;
      cmd                <= '0;
      val1               <= '0;
      val2               <= '0;
    end else if (en) begin
      pos                <= pos + POS_W'(1);
      text_ended         <= text_ended_next;
      comma_seen         <= comma_seen_next;
      running_check      <= running_check_next;
      check_before_comma <= check_before_comma_next;
      check_digits       <= check_digits_next;
      check_bad_char     <= check_bad_char_next;
      field_number       <= field_number_next;
      seg_len            <= seg_len_next;
      seg_value          <= seg_value_next;
      seg_chars          <= seg_chars_next;
      first_byte         <= first_byte_next;
      node               <= node_next;
      rev                <= rev_next;
      variant            <= variant_next;
      cfg                <= cfg_next;
      cmd                <= cmd_next;
      val1               <= val1_next;
      val2               <= val2_next;
    end
  end

`ifndef SYNTHESIS
  a_frame_wraps: assert property (@(posedge clk) disable iff (rst)
    (en && last) |=> (pos == '0 && !comma_seen && !text_ended))
    else $error("frame state not cleared after last byte");

  a_no_comma_no_field: assert property (@(posedge clk) disable iff (rst)
    !comma_seen |-> (field_number == FLD_NODE && check_before_comma == CRC_INIT))
    else $error("field advanced without a comma");

  a_empty_segment: assert property (@(posedge clk) disable iff (rst)
    (seg_len == '0) |-> (seg_value == '0 && seg_chars == '0))
    else $error("empty segment holds data");

  a_ended_frozen: assert property (@(posedge clk) disable iff (rst)
    (en && text_ended && !last) |=> $stable(running_check) && $stable(seg_len))
    else $error("state moved after end of text");
`endif

endmodule

>>> src/ascii_frame_parser_crc8.sv
// top level of the ascii frame parser: input word register, frame core, result register
// depends on afp_pkg and afp_frame_core
`timescale 1ns / 1ps

// ascii_frame_parser_crc8 takes a frame of FRAME_BYTES (32) ascii bytes, one word per
// cycle on the byte channel unless byte_stall holds it, and after the last byte of each
// frame hands out one result word carrying frame_valid and the decoded fields. the text
// ends at the first zero byte; the last comma opens a decimal checksum that must match a
// crc-8 (poly 0x07, init 0xff) over the text before it. a frame that fails the check, or
// starts with a zero byte, gives a result of all zeros. the block takes one byte every
// cycle unless the last byte of a frame is held back; the per-byte crc step and decimal
// accumulate in the frame core are combinational. a byte waits in the input register, and
// the frame's last byte leaves it at the same edge that loads the result register and
// raises result_valid. bytes keep flowing while a result waits; only the last byte of
// the next frame is held back if the previous result is still stalled.
module ascii_frame_parser_crc8 (
  input  logic        clk,
  input  logic        rst,
  // byte channel
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  rx_byte,
  // result channel
  output logic        result_valid,
  input  logic        result_stall,
  output logic        frame_valid,
  output logic [7:0]  node_number,
  output logic [7:0]  revision,
  output logic [23:0] variant_code,
  output logic [7:0]  config_number,
  output logic [47:0] command_text,
  output logic [15:0] first_value,
  output logic [15:0] second_value,
  output logic [7:0]  received_check
);
  import afp_pkg::*;

  // input word register
  logic        s1_valid;
  logic [7:0]  s1_byte;

  // core hookup
  logic        advance;
  logic        core_last;
  afp_result_t core_res;
  afp_result_t res_q;

  afp_frame_core u_core (
    .clk     (clk),
    .rst     (rst),
    .en      (advance),
    .rx_byte (s1_byte),
    .last    (core_last),
    .res     (core_res)
  );

  // the held word moves on unless it closes a frame and the result slot is blocked
  assign advance    = s1_valid && !(core_last && result_valid && result_stall);
  assign byte_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!byte_stall) begin
      s1_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!byte_stall) begin
      s1_byte <= rx_byte;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && core_last) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && core_last) begin
      res_q <= core_res;
    end
  end

  assign frame_valid    = res_q.frame_valid;
  assign node_number    = res_q.node_number;
  assign revision       = res_q.revision;
  assign variant_code   = res_q.variant_code;
  assign config_number  = res_q.config_number;
  assign command_text   = res_q.command_text;
  assign first_value    = res_q.first_value;
  assign second_value   = res_q.second_value;
  assign received_check = res_q.received_check;

endmodule
